>>> hdl/pmds_pkg.sv
// shared constants, types and helper functions for the patch minimum depth sampler
package pmds_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_PATCH   = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int OFF_W   = $clog2(MAX_PATCH);
   localparam int DIM_W   = 11;
   localparam int PS_W    = 7;
   localparam int DEPTH_W = 16;
   localparam int COLOR_W = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_PATCH_SIZE,
      CSR_DEPTH_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]   frame_width;
      logic [DIM_W-1:0]   frame_height;
      logic [PS_W-1:0]    patch_side;
      logic [DEPTH_W-1:0] depth_limit;
   } cfg_type;

   // classified pixel handed from the front end to the store update
   typedef struct packed {
      logic [COL_W-1:0]   idx;
      logic               start;
      logic               last;
      logic               lidar;
      logic               qualify;
      logic [DEPTH_W-1:0] depth;
      logic [COL_W-1:0]   x;
      logic [ROW_W-1:0]   y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } item_type;

   // one patch store entry
   typedef struct packed {
      logic               lidar;
      logic               valid;
      logic [DEPTH_W-1:0] depth;
      logic [COL_W-1:0]   x;
      logic [ROW_W-1:0]   y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } entry_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [PS_W-1:0] clamp_patch(input logic [PS_W-1:0] v);
      logic [PS_W-1:0] r;
      if (v == '0) begin
         r = PS_W'(1);
      end else if (v > PS_W'(MAX_PATCH)) begin
         r = PS_W'(MAX_PATCH);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> hdl/pmds_if.sv
// channel interfaces: pixel input, sample output and register write port
interface pmds_req_if;
   logic                          valid;
   logic                          ready;
   logic [pmds_pkg::DEPTH_W-1:0]  lidar_mm;
   logic [pmds_pkg::DEPTH_W-1:0]  dense_mm;
   logic                          near_lidar;
   logic [pmds_pkg::COLOR_W-1:0]  red;
   logic [pmds_pkg::COLOR_W-1:0]  green;
   logic [pmds_pkg::COLOR_W-1:0]  blue;

   modport source (output valid, lidar_mm, dense_mm, near_lidar, red, green, blue,
                   input ready);
   modport sink (input valid, lidar_mm, dense_mm, near_lidar, red, green, blue,
                 output ready);
endinterface

interface pmds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pmds_pkg::COL_W-1:0]    pixel_x;
   logic [pmds_pkg::ROW_W-1:0]    pixel_y;
   logic [pmds_pkg::DEPTH_W-1:0]  chosen_depth;
   logic [pmds_pkg::COLOR_W-1:0]  out_red;
   logic [pmds_pkg::COLOR_W-1:0]  out_green;
   logic [pmds_pkg::COLOR_W-1:0]  out_blue;

   modport source (output valid, pixel_x, pixel_y, chosen_depth, out_red, out_green, out_blue,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, chosen_depth, out_red, out_green, out_blue,
                 output ready);
endinterface

interface pmds_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pmds_pkg::CSR_INDEX_W-1:0] index;
   logic [pmds_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/pmds_front.sv
// front end: raster counters and pixel classification
module pmds_front (
   input  logic               clock,
   input  logic               reset,
   pmds_req_if.sink           req_ch,
   input  pmds_pkg::cfg_type  cfg,
   input  logic               queue_full,
   output logic               push,
   output pmds_pkg::item_type item
);
   import pmds_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [OFF_W-1:0] offx_ff, offx_in;
   logic [OFF_W-1:0] offy_ff, offy_in;
   logic [COL_W-1:0] pcol_ff, pcol_in;

   logic [DIM_W-1:0] w;
   logic [DIM_W-1:0] h;
   logic [PS_W-1:0]  ps;
   logic             end_row;
   logic             end_frame;
   logic             end_x;
   logic             end_y;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   always_comb begin
      w         = clamp_dim(cfg.frame_width, DIM_W'(MAX_WIDTH));
      h         = clamp_dim(cfg.frame_height, DIM_W'(MAX_HEIGHT));
      ps        = clamp_patch(cfg.patch_side);
      end_row   = (DIM_W'(col_ff) + DIM_W'(1)) >= w;
      end_frame = (DIM_W'(row_ff) + DIM_W'(1)) >= h;
      end_x     = ((PS_W'(offx_ff) + PS_W'(1)) >= ps) || end_row;
      end_y     = ((PS_W'(offy_ff) + PS_W'(1)) >= ps) || end_frame;

      item.idx     = pcol_ff;
      item.start   = (offx_ff == '0) && (offy_ff == '0);
      item.last    = end_x && end_y;
      item.lidar   = req_ch.lidar_mm != '0;
      item.qualify = (req_ch.dense_mm != '0) && (req_ch.dense_mm < cfg.depth_limit)
                     && !req_ch.near_lidar;
      item.depth   = req_ch.dense_mm;
      item.x       = col_ff;
      item.y       = row_ff;
      item.red     = req_ch.red;
      item.green   = req_ch.green;
      item.blue    = req_ch.blue;

      col_in  = col_ff;
      row_in  = row_ff;
      offx_in = offx_ff;
      offy_in = offy_ff;
      pcol_in = pcol_ff;
      if (push) begin
         if (end_row) begin
            col_in  = '0;
            offx_in = '0;
            pcol_in = '0;
            if (end_frame) begin
               row_in  = '0;
               offy_in = '0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               offy_in = end_y ? '0 : offy_ff + OFF_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
            if (end_x) begin
               offx_in = '0;
               pcol_in = pcol_ff + COL_W'(1);
            end else begin
               offx_in = offx_ff + OFF_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         offx_ff <= '0;
         offy_ff <= '0;
         pcol_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         offx_ff <= offx_in;
         offy_ff <= offy_in;
         pcol_ff <= pcol_in;
      end
   end

endmodule

>>> hdl/pmds_queue.sv
// short queue of classified pixels between front end and store update
module pmds_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pmds_pkg::item_type push_item,
   input  logic               pop,
   output pmds_pkg::item_type head,
   output logic               empty,
   output logic               full
);
   import pmds_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      empty     = count_ff == '0;
      full      = count_ff == CNT_W'(QUEUE_DEPTH);
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count past its depth");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !empty)
      else $error("pushed transaction lost from queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty queue");

endmodule

>>> hdl/pmds_back.sv
// back end: patch store read-modify-write and result register
module pmds_back (
   input  logic               clock,
   input  logic               reset,
   input  pmds_pkg::item_type head,
   input  logic               empty,
   output logic               pop,
   pmds_rsp_if.source         rsp_ch
);
   import pmds_pkg::*;

   entry_type store_mem [MAX_WIDTH];
   entry_type rdata_ff;

   logic      b_valid_ff, b_valid_in;
   item_type  b_item_ff;
   logic      b_fwd_ff, b_fwd_in;
   entry_type b_fwd_entry_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   entry_type rsp_entry_ff;

   entry_type base;
   entry_type merged;
   logic      emit;
   logic      out_free;
   logic      b_leave;

   always_comb begin
      if (b_item_ff.start) begin
         base = '0;
      end else if (b_fwd_ff) begin
         base = b_fwd_entry_ff;
      end else begin
         base = rdata_ff;
      end
      merged       = base;
      merged.lidar = base.lidar | b_item_ff.lidar;
      // strict compare keeps the earliest pixel on ties
      if (b_item_ff.qualify && (!base.valid || (b_item_ff.depth < base.depth))) begin
         merged.valid = 1'b1;
         merged.depth = b_item_ff.depth;
         merged.x     = b_item_ff.x;
         merged.y     = b_item_ff.y;
         merged.red   = b_item_ff.red;
         merged.green = b_item_ff.green;
         merged.blue  = b_item_ff.blue;
      end
      emit     = b_item_ff.last && !merged.lidar && merged.valid;
      out_free = !rsp_valid_ff || rsp_ch.ready;
      b_leave  = b_valid_ff && (!emit || out_free);
      pop      = !empty && (!b_valid_ff || b_leave);

      b_valid_in = pop || (b_valid_ff && !b_leave);
      // same entry written on the edge it is read: take the written value
      b_fwd_in   = b_leave && (b_item_ff.idx == head.idx);

      rsp_valid_in = rsp_valid_ff;
      if (b_leave && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_leave) begin
         store_mem[b_item_ff.idx] <= merged;
      end
      if (pop) begin
         rdata_ff <= store_mem[head.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_item_ff      <= head;
         b_fwd_entry_ff <= merged;
      end
      if (b_leave && emit) begin
         rsp_entry_ff <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         b_fwd_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         if (pop) begin
            b_fwd_ff <= b_fwd_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pixel_x      = rsp_entry_ff.x;
   assign rsp_ch.pixel_y      = rsp_entry_ff.y;
   assign rsp_ch.chosen_depth = rsp_entry_ff.depth;
   assign rsp_ch.out_red      = rsp_entry_ff.red;
   assign rsp_ch.out_green    = rsp_entry_ff.green;
   assign rsp_ch.out_blue     = rsp_entry_ff.blue;

   a_held_stage_blocks_pop: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_leave) |-> !pop)
      else $error("queue popped while the update stage is held");

   a_emit_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (b_leave && emit) |=> rsp_valid_ff)
      else $error("emitted sample missing from output register");

   a_depth_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ch.chosen_depth != '0))
      else $error("output sample carries zero depth");

endmodule

>>> hdl/patch_min_depth_sampler.sv
// top level: per-patch minimum dense depth sampler with config registers
// result path: a pixel that closes a patch passes the queue, the store update stage and the output register to rsp
// throughput: one pixel per cycle while rsp is not stalled, set by the one read and one write port of the patch store
// reset: counters to frame origin, registers to defaults, queue and output emptied
// the patch store is not cleared, each entry is rewritten at the first pixel of its patch
module patch_min_depth_sampler (
   input  logic       clock,
   input  logic       reset,
   pmds_req_if.sink   req_ch,
   pmds_rsp_if.source rsp_ch,
   pmds_csr_if.sink   csr_ch
);
   import pmds_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     queue_full;
   logic     queue_empty;
   logic     push;
   logic     pop;
   item_type push_item;
   item_type head;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_ch.data[DIM_W-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_ch.data[DIM_W-1:0];
            CSR_PATCH_SIZE:   cfg_in.patch_side   = csr_ch.data[PS_W-1:0];
            CSR_DEPTH_LIMIT:  cfg_in.depth_limit  = csr_ch.data[DEPTH_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= DIM_W'(640);
         cfg_ff.frame_height <= DIM_W'(480);
         cfg_ff.patch_side   <= PS_W'(16);
         cfg_ff.depth_limit  <= DEPTH_W'(65535);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end classifies each accepted pixel transaction
   pmds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   // decouples input stalls from output stalls
   pmds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // store update, candidate selection and output register
   pmds_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (queue_empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
